/* hdl/iapee_pkg.sv */
// Package: shared constants for the IAP EEPROM controller.
`timescale 1ns / 1ps
package iapee_pkg;

  // store geometry defaults
  localparam int unsigned StoreBytesDef  = 4096;
  localparam int unsigned SectorBytesDef = 512;

  localparam int unsigned AddrW = 16;
  localparam logic [AddrW-1:0] WindowBaseRst = 16'h2000;

  // register selects
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_ADDR_HI = 3'd1;
  localparam logic [2:0] REG_ADDR_LO = 3'd2;
  localparam logic [2:0] REG_CMD     = 3'd3;
  localparam logic [2:0] REG_TRIG    = 3'd4;
  localparam logic [2:0] REG_CTRL    = 3'd5;

  // unlock sequence
  localparam logic [7:0] TRIG_FIRST  = 8'h46;
  localparam logic [7:0] TRIG_SECOND = 8'hB9;

  // commands
  localparam logic [7:0] CMD_READ    = 8'h01;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_ERASE   = 8'h03;

  localparam int unsigned CTRL_EN_BIT = 7;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;

endpackage

/* hdl/iapee_store.sv */
// Single-port byte store with registered read data.
`timescale 1ns / 1ps
module iapee_store import iapee_pkg::*; #(
  parameter int unsigned DEPTH = StoreBytesDef,
  parameter int unsigned AW    = $clog2(StoreBytesDef)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/iap_eeprom_controller.sv */
// Top level: IAP EEPROM controller with register file, sequencer and byte store.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | is_write_i, reg_select_i, write_value_i
//  out     | output    | out_valid_o/out_ready_i| read_value_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o| window_base_i
//
// Every register transaction is answered in the cycle after it is taken: the result
// is known at accept time and lands in the output register.
// A trigger that launches a command keeps in_ready_o low while the sequencer runs:
// read and program step through offset, memory read and write-back; erase steps
// through the sector-start division, the clip to the store end and the fill; the
// one memory port sets the pace. After reset the sequencer sweeps the store to 0xFF
// before in_ready_o rises. Config writes are taken at any time (cfg_ready_o is high).
// A stalled result (out_valid_o high, out_ready_i low) holds off new transactions.
`timescale 1ns / 1ps
module iap_eeprom_controller import iapee_pkg::*; #(
  parameter int unsigned STORE_BYTES  = StoreBytesDef,
  parameter int unsigned SECTOR_BYTES = SectorBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // register access
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       is_write_i,
  input  logic [2:0] reg_select_i,
  input  logic [7:0] write_value_i,
  // response
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_value_o,
  // window base config
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [15:0] window_base_i
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam logic [AddrW-1:0] StoreLen  = AddrW'(STORE_BYTES);
  localparam logic [AddrW-1:0] SectorLen = AddrW'(SECTOR_BYTES);
  localparam logic [AddrW-1:0] StoreLast = AddrW'(STORE_BYTES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset erase sweep
    ST_IDLE,
    ST_EXEC,    // decode command on the registered offset
    ST_RD_WAIT, // read data returning for command read
    ST_PG_WR,   // AND data into the cell
    ST_ER_DIV,  // find sector start by repeated subtract
    ST_ER_SETUP,// clip sector end to store
    ST_ER_FILL  // write 0xFF across the sector
  } state_e;

  state_e           state_q;
  logic [7:0]       data_q, cmd_q, ctrl_q;
  logic [AddrW-1:0] addr_q, base_q;
  logic             unlock_q;
  logic             out_valid_q;
  logic [7:0]       rd_q;
  logic [AddrW-1:0] off_q, rem_q, ptr_q, stop_q;

  logic             in_acc;
  logic [7:0]       rd_mux;
  logic             in_window;
  logic [AddrW-1:0] stop_full;

  // store port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign in_ready_o   = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc       = in_valid_i && in_ready_o;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_q;

  assign in_window = off_q < StoreLen;
  assign stop_full = ptr_q + SectorLen;

  // register read mux; write-only and unused selects read zero
  always_comb begin
    rd_mux = '0;
    if (!is_write_i) begin
      case (reg_select_i)
        REG_DATA:    rd_mux = data_q;
        REG_ADDR_HI: rd_mux = addr_q[15:8];
        REG_ADDR_LO: rd_mux = addr_q[7:0];
        REG_CMD:     rd_mux = cmd_q;
        REG_CTRL:    rd_mux = ctrl_q;
        default:     rd_mux = '0;
      endcase
    end
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = off_q[AW-1:0];
    mem_wdata = ERASED_BYTE;
    case (state_q)
      ST_CLEAR, ST_ER_FILL: begin
        mem_we   = 1'b1;
        mem_addr = ptr_q[AW-1:0];
      end
      ST_EXEC: begin
        mem_re = in_window && (cmd_q == CMD_READ || cmd_q == CMD_PROGRAM);
      end
      ST_PG_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & data_q;
      end
      default: ;
    endcase
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= WindowBaseRst;
    end else if (cfg_valid_i) begin
      base_q <= window_base_i;
    end
  end

  // sequencer, register file and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      data_q      <= '0;
      addr_q      <= '0;
      cmd_q       <= '0;
      ctrl_q      <= '0;
      unlock_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rd_q        <= '0;
      off_q       <= '0;
      rem_q       <= '0;
      ptr_q       <= '0;
      stop_q      <= '0;
    end else begin
      // a new transaction refills the output register in the same cycle
      if (out_valid_q && out_ready_i && !in_acc) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          if (ptr_q == StoreLast) begin
            state_q <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            out_valid_q <= 1'b1;
            rd_q        <= rd_mux;
            off_q       <= addr_q - base_q;
            if (is_write_i) begin
              case (reg_select_i)
                REG_DATA:    data_q       <= write_value_i;
                REG_ADDR_HI: addr_q[15:8] <= write_value_i;
                REG_ADDR_LO: addr_q[7:0]  <= write_value_i;
                REG_CMD:     cmd_q        <= write_value_i;
                REG_CTRL:    ctrl_q       <= write_value_i;
                REG_TRIG: begin
                  if (write_value_i == TRIG_FIRST) begin
                    unlock_q <= 1'b1;
                  end else begin
                    unlock_q <= 1'b0;
                    if (write_value_i == TRIG_SECOND && unlock_q && ctrl_q[CTRL_EN_BIT]) begin
                      state_q <= ST_EXEC;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end

        ST_EXEC: begin
          rem_q <= off_q;
          case (cmd_q)
            CMD_READ: begin
              if (in_window) begin
                state_q <= ST_RD_WAIT;
              end else begin
                data_q  <= ERASED_BYTE;
                state_q <= ST_IDLE;
              end
            end
            CMD_PROGRAM: state_q <= in_window ? ST_PG_WR : ST_IDLE;
            CMD_ERASE:   state_q <= in_window ? ST_ER_DIV : ST_IDLE;
            default:     state_q <= ST_IDLE;
          endcase
        end

        ST_RD_WAIT: begin
          data_q  <= mem_rdata;
          state_q <= ST_IDLE;
        end

        ST_PG_WR: state_q <= ST_IDLE;

        ST_ER_DIV: begin
          if (rem_q >= SectorLen) begin
            rem_q <= rem_q - SectorLen;
          end else begin
            ptr_q   <= off_q - rem_q;
            state_q <= ST_ER_SETUP;
          end
        end

        ST_ER_SETUP: begin
          stop_q  <= (stop_full > StoreLen) ? StoreLen : stop_full;
          state_q <= ST_ER_FILL;
        end

        ST_ER_FILL: begin
          if (ptr_q + 1'b1 == stop_q) begin
            state_q <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  iapee_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

/* hdl/iapee_checker.sv */
// Port-level checker for the IAP EEPROM controller, with its bind.
`timescale 1ns / 1ps
module iapee_checker import iapee_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       is_write_i,
  input logic [2:0] reg_select_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_value_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // every transaction produces a response on the next cycle
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("no response after accepted transaction");

  // writes answer zero
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_write_i |=> read_value_o == 8'h00)
    else $error("write response not zero");

  // trigger and unused selects read as zero
  a_noread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_write_i && (reg_select_i == REG_TRIG || reg_select_i > REG_CTRL)
    |=> read_value_o == 8'h00)
    else $error("write-only or unused register read not zero");

  // a held response blocks new transactions
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("transaction taken while response stalled");

  // stalled response payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o))
    else $error("stalled response changed");

endmodule

bind iap_eeprom_controller iapee_checker u_iapee_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .is_write_i   (is_write_i),
  .reg_select_i (reg_select_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_value_o (read_value_o)
);

/* test/iap_eeprom_controller_tb.sv */
// Self-checking testbench for the IAP EEPROM controller: register accesses, unlock and commands.
`timescale 1ns / 1ps

import iapee_pkg::*;

// Shadow of the controller: register file, unlock state and byte store,
// plus the queue of read values the block still owes us.
class eeprom_shadow;
  logic [15:0] window_base;
  logic [7:0]  data_q;
  logic [15:0] addr_q;
  logic [7:0]  cmd_q;
  logic [7:0]  ctrl_q;
  bit          unlocked;
  logic [7:0]  cells [StoreBytesDef];
  logic [7:0]  expected_reads [$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned reads_run;
  int unsigned programs_run;
  int unsigned erases_run;
  int unsigned outside_runs;
  int unsigned disabled_runs;
  int unsigned noop_runs;

  function new();
    window_base = WindowBaseRst;
    data_q      = '0;
    addr_q      = '0;
    cmd_q       = '0;
    ctrl_q      = '0;
    unlocked    = 1'b0;
    foreach (cells[i]) cells[i] = ERASED_BYTE;
  endfunction

  function void set_window(logic [15:0] base);
    window_base = base;
  endfunction

  function int pending();
    return expected_reads.size();
  endfunction

  // Apply one accepted transaction and queue the value it returns.
  function void note_access(bit wr, logic [2:0] sel, logic [7:0] val);
    logic [7:0]  rd;
    logic [15:0] off;
    int unsigned sector_lo;
    int unsigned sector_hi;
    rd = 8'h00;
    if (wr) begin
      case (sel)
        REG_DATA:    data_q = val;
        REG_ADDR_HI: addr_q[15:8] = val;
        REG_ADDR_LO: addr_q[7:0] = val;
        REG_CMD:     cmd_q = val;
        REG_CTRL:    ctrl_q = val;
        REG_TRIG: begin
          if (val == TRIG_FIRST) begin
            unlocked = 1'b1;
          end else if (val == TRIG_SECOND && unlocked) begin
            unlocked = 1'b0;
            if (!ctrl_q[CTRL_EN_BIT]) begin
              disabled_runs++;
            end else begin
              off = addr_q - window_base;
              if (off >= StoreBytesDef && cmd_q inside {CMD_READ, CMD_PROGRAM, CMD_ERASE})
                outside_runs++;
              case (cmd_q)
                CMD_READ: begin
                  reads_run++;
                  data_q = (off < StoreBytesDef) ? cells[off] : ERASED_BYTE;
                end
                CMD_PROGRAM: begin
                  programs_run++;
                  if (off < StoreBytesDef) cells[off] = cells[off] & data_q;
                end
                CMD_ERASE: begin
                  erases_run++;
                  if (off < StoreBytesDef) begin
                    sector_lo = (int'(off) / SectorBytesDef) * SectorBytesDef;
                    sector_hi = sector_lo + SectorBytesDef;
                    if (sector_hi > StoreBytesDef) sector_hi = StoreBytesDef;
                    for (int unsigned i = sector_lo; i < sector_hi; i++) cells[i] = ERASED_BYTE;
                  end
                end
                default: noop_runs++;
              endcase
            end
          end else begin
            unlocked = 1'b0;
          end
        end
        default: ;
      endcase
    end else begin
      case (sel)
        REG_DATA:    rd = data_q;
        REG_ADDR_HI: rd = addr_q[15:8];
        REG_ADDR_LO: rd = addr_q[7:0];
        REG_CMD:     rd = cmd_q;
        REG_CTRL:    rd = ctrl_q;
        default:     rd = 8'h00;
      endcase
    end
    expected_reads.push_back(rd);
  endfunction

  function void check_read(logic [7:0] got);
    logic [7:0] exp_val;
    results_seen++;
    if (expected_reads.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result 0x%02h arrived with nothing expected", $realtime, got);
    end else begin
      exp_val = expected_reads.pop_front();
      if (got !== exp_val) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: read_value mismatch, expected 0x%02h got 0x%02h",
                   $realtime, exp_val, got);
      end
    end
  endfunction
endclass

module iap_eeprom_controller_tb;

  // access kinds and the two selects the block does not decode
  localparam bit         ACC_READ   = 1'b0;
  localparam bit         ACC_WRITE  = 1'b1;
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  localparam logic [7:0] CMD_NONE   = 8'h00;

  localparam int unsigned TotalItems = 1900;
  localparam int unsigned NumPhases  = 6;
  // worst sequencer run: an erase of the last sector, plus some margin
  localparam int unsigned TailCycles = 3 + StoreBytesDef / SectorBytesDef + SectorBytesDef + 16;
  // nothing may be quiet for longer than the post-reset sweep plus an erase, with room
  localparam int unsigned WatchdogLimit = 4 * (StoreBytesDef + TailCycles + 32);

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        is_write_i    = 1'b0;
  logic [2:0]  reg_select_i  = '0;
  logic [7:0]  write_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  read_value_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] window_base_i = WindowBaseRst;

  eeprom_shadow sb;

  // stimulus bookkeeping
  int unsigned items_sent  = 0;
  int unsigned in_run_left = 0;
  bit          in_no_idle  = 1'b0;
  logic [15:0] cur_base    = WindowBaseRst;
  logic [15:0] hot_base    = '0;   // small busy region so programs and reads meet

  iap_eeprom_controller #(
    .STORE_BYTES (StoreBytesDef),
    .SECTOR_BYTES(SectorBytesDef)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .is_write_i   (is_write_i),
    .reg_select_i (reg_select_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .window_base_i(window_base_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One register transaction. Valid stays high after acceptance; the next call
  // either keeps it up (no gap) or drops it, so valid gets one update per step.
  // Handshakes are sampled right after the edge, before any NBA of that edge lands.
  task automatic send_access(input bit wr, input logic [2:0] sel, input logic [7:0] val);
    int unsigned gap;
    if (in_run_left == 0) begin
      in_no_idle  = ($urandom_range(0, 3) == 0);
      in_run_left = $urandom_range(8, 64);
    end
    in_run_left--;
    gap = in_no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    is_write_i    <= wr;
    reg_select_i  <= sel;
    write_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(wr, sel, val);
    items_sent++;
  endtask

  // Hold off the sender until every queued read value has come back.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_window(input logic [15:0] base);
    cfg_valid_i   <= 1'b1;
    window_base_i <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_window(base);
    cur_base = base;
  endtask

  // Mostly addresses inside the window (edges, sector seams, hot region),
  // some just past either end and some anywhere.
  function automatic logic [15:0] pick_address();
    logic [15:0] off;
    case ($urandom_range(0, 11))
      0:          off = 16'd0;
      1:          off = 16'(StoreBytesDef - 1);
      2:          off = 16'($urandom_range(1, StoreBytesDef / SectorBytesDef - 1) * SectorBytesDef
                            - $urandom_range(0, 1));
      3, 4, 5, 6: off = hot_base + 16'($urandom_range(0, 15));
      7, 8:       off = 16'($urandom_range(0, StoreBytesDef - 1));
      9:          off = 16'(StoreBytesDef + $urandom_range(0, 255));
      10:         off = 16'(65535 - $urandom_range(0, 255));
      default:    off = 16'($urandom);
    endcase
    return cur_base + off;
  endfunction

  // A well-formed command: optional control write, address, data, command,
  // unlock pair (sometimes broken), then read back.
  task automatic command_sequence();
    logic [15:0] addr;
    logic [7:0]  cmd;
    int unsigned pick;
    addr = pick_address();
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 6) == 0) send_access(ACC_WRITE, REG_CTRL, {1'b0, 7'($urandom)});
      else send_access(ACC_WRITE, REG_CTRL, {1'b1, 7'($urandom)});
    end

    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      send_access(ACC_WRITE, REG_ADDR_LO, addr[7:0]);
      send_access(ACC_WRITE, REG_ADDR_HI, addr[15:8]);
    end else if (pick == 1) begin
      send_access(ACC_WRITE, REG_ADDR_LO, addr[7:0]);
    end else begin
      send_access(ACC_WRITE, REG_ADDR_HI, addr[15:8]);
      send_access(ACC_WRITE, REG_ADDR_LO, addr[7:0]);
    end

    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = CMD_READ;
    else if (pick < 75) cmd = CMD_PROGRAM;
    else if (pick < 82) cmd = CMD_ERASE;
    else                cmd = ($urandom_range(0, 1) != 0) ? CMD_NONE : 8'($urandom);

    // programming with one cleared bit wears the cells down slowly
    if (cmd == CMD_PROGRAM) begin
      if ($urandom_range(0, 1) != 0) send_access(ACC_WRITE, REG_DATA, 8'($urandom));
      else send_access(ACC_WRITE, REG_DATA, ~(8'h01 << $urandom_range(0, 7)));
    end else if ($urandom_range(0, 2) == 0) begin
      send_access(ACC_WRITE, REG_DATA, 8'($urandom));
    end
    send_access(ACC_WRITE, REG_CMD, cmd);

    case ($urandom_range(0, 9))
      6: begin
        // a non-trigger access between the two keeps the unlock armed
        send_access(ACC_WRITE, REG_TRIG, TRIG_FIRST);
        send_access(ACC_READ, 3'($urandom_range(0, 7)), 8'($urandom));
        send_access(ACC_WRITE, REG_TRIG, TRIG_SECOND);
      end
      7: begin
        send_access(ACC_WRITE, REG_TRIG, TRIG_FIRST);
        send_access(ACC_WRITE, REG_TRIG, TRIG_FIRST);
        send_access(ACC_WRITE, REG_TRIG, TRIG_SECOND);
      end
      8: send_access(ACC_WRITE, REG_TRIG, TRIG_SECOND);
      9: begin
        // a stray trigger value drops the unlock, so the second byte does nothing
        send_access(ACC_WRITE, REG_TRIG, TRIG_FIRST);
        send_access(ACC_WRITE, REG_TRIG, 8'($urandom));
        if ($urandom_range(0, 1) != 0) send_access(ACC_WRITE, REG_TRIG, TRIG_SECOND);
      end
      default: begin
        send_access(ACC_WRITE, REG_TRIG, TRIG_FIRST);
        send_access(ACC_WRITE, REG_TRIG, TRIG_SECOND);
      end
    endcase

    if ($urandom_range(0, 9) < 7) send_access(ACC_READ, REG_DATA, 8'($urandom));
    if ($urandom_range(0, 4) == 0) send_access(ACC_READ, 3'($urandom_range(0, 7)), 8'($urandom));
  endtask

  // Result side: random stalls per result, with stretches of none.
  initial begin : result_sink
    int unsigned stall;
    int unsigned run_left;
    bit          no_stall;
    run_left = 0;
    no_stall = 1'b0;
    @(posedge clk_i);
    forever begin
      if (run_left == 0) begin
        no_stall = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(8, 64);
      end
      run_left--;
      stall = no_stall ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_read(read_value_o);
    end
  end

  // Ends the run if no channel completes a transaction for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $realtime, WatchdogLimit);
    $display("iap_eeprom_controller_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] top_addr;
    logic [15:0] window_bases [NumPhases];
    int unsigned pick;
    int unsigned phase_end;
    sb = new();
    // reset value, both extremes, a window that wraps past 0xFFFF, random, unaligned
    window_bases = '{WindowBaseRst, 16'h0000, 16'hFFFF, 16'hF400, 16'($urandom), 16'h8001};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        // a read is only taken once the sequencer is done, so after it drains
        // the block is fully idle and the window can move
        send_access(ACC_READ, REG_CMD, 8'($urandom));
        quiesce();
      end
      write_window(window_bases[p]);
      hot_base = 16'($urandom_range(0, StoreBytesDef - 16));

      if (p == 0) begin
        // every select read at reset, trigger and spare selects read zero
        for (int s = 0; s < 8; s++) send_access(ACC_READ, 3'(s), 8'hFF);
        send_access(ACC_WRITE, REG_SPARE6, 8'hFF);
        send_access(ACC_WRITE, REG_SPARE7, 8'h00);
        // enable with wait-time bits set, which must read back unchanged
        send_access(ACC_WRITE, REG_CTRL, 8'h83);
        send_access(ACC_READ, REG_CTRL, 8'h00);
        // program the last byte of the window, then read it back through the data register
        top_addr = cur_base + 16'(StoreBytesDef - 1);
        send_access(ACC_WRITE, REG_ADDR_HI, top_addr[15:8]);
        send_access(ACC_WRITE, REG_ADDR_LO, top_addr[7:0]);
        send_access(ACC_WRITE, REG_DATA, 8'h5A);
        send_access(ACC_WRITE, REG_CMD, CMD_PROGRAM);
        send_access(ACC_WRITE, REG_TRIG, TRIG_FIRST);
        send_access(ACC_WRITE, REG_TRIG, TRIG_SECOND);
        send_access(ACC_WRITE, REG_DATA, 8'h00);
        send_access(ACC_WRITE, REG_CMD, CMD_READ);
        send_access(ACC_WRITE, REG_TRIG, TRIG_FIRST);
        send_access(ACC_WRITE, REG_TRIG, TRIG_SECOND);
        send_access(ACC_READ, REG_DATA, 8'h00);
      end

      phase_end = (TotalItems * (p + 1)) / NumPhases;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) quiesce();
        else if (pick < 34) command_sequence();
        else send_access(1'($urandom), 3'($urandom), 8'($urandom));
      end
    end

    // drain, then give a trailing erase time to finish and any stray result time to show
    quiesce();
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d register transactions over %0d window bases, %0d results checked",
             items_sent, NumPhases, sb.results_seen);
    $display("commands: %0d read, %0d program, %0d erase, %0d outside, %0d disabled, %0d no-op",
             sb.reads_run, sb.programs_run, sb.erases_run, sb.outside_runs,
             sb.disabled_runs, sb.noop_runs);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("iap_eeprom_controller_tb passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("iap_eeprom_controller_tb failed");
    end
    $finish;
  end

endmodule

/* iap_eeprom_controller.f */
hdl/iapee_pkg.sv
hdl/iapee_store.sv
hdl/iap_eeprom_controller.sv
hdl/iapee_checker.sv
test/iap_eeprom_controller_tb.sv
